[sv/lzwd_pkg.sv]
// shared types and constants for the lzss window decompressor
// no dependencies; imported by every module of the block except lzwd_ram
package lzwd_pkg;

   // window geometry and stream start point
   localparam int WINDOW_SIZE_DEF = 4096;
   localparam int START_POS       = 4078;

   // token format: 12-bit window position, 4-bit length code plus 3
   localparam int POS_W      = 12;
   localparam int LEN_W      = 5;
   localparam int MIN_LEN    = 3;
   localparam int MAX_LEN    = 18;
   localparam int FLAG_CNT_W = 4;
   localparam logic [FLAG_CNT_W-1:0] FLAG_COUNT = 4'd8;

   // one compressed input byte
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // one decompressed result
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_item;
      logic       end_of_stream;
      logic       truncated;
   } rsp_type;

   // controller to datapath commands
   typedef struct packed {
      logic             load;        // load output register (and window on data)
      logic             from_ram;    // output byte comes from the window read
      logic [7:0]       out_byte;    // literal byte when not from the window
      logic             byte_valid;
      logic             last_item;
      logic             eos;
      logic             trunc;
      logic             rd_load;     // load copy read pointer
      logic [POS_W-1:0] rd_pos;
      logic             rd_issue;    // issue one window read and advance pointer
   } cmd_type;

endpackage

[sv/lzwd_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/lzwd_ctrl.sv]
// controller for the lzss window decompressor: flag/token parsing and copy sequencing
// depends on lzwd_pkg; drives lzwd_dp through cmd_type
module lzwd_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   input  logic              out_free,
   output lzwd_pkg::cmd_type cmd
);
   import lzwd_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_COPY = 1'b1;

   logic                  state_ff, state_in;
   logic [7:0]            flag_bits_ff, flag_bits_in;
   logic [FLAG_CNT_W-1:0] flags_left_ff, flags_left_in;
   logic [7:0]            token_hi_ff, token_hi_in;
   logic                  token_pend_ff, token_pend_in;
   logic [LEN_W-1:0]      remain_ff, remain_in;
   logic                  pend_ff, pend_in;
   logic                  last_ff, last_in;

   logic accept;
   logic is_copy, is_flag, is_lit, is_high;
   logic load, issue, fin;

   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept    = req_valid && req_ready;

   // classify the incoming byte
   assign is_copy = token_pend_ff;
   assign is_flag = !token_pend_ff && (flags_left_ff == '0);
   assign is_lit  = !token_pend_ff && (flags_left_ff != '0) && flag_bits_ff[0];
   assign is_high = !token_pend_ff && (flags_left_ff != '0) && !flag_bits_ff[0];

   // copy sequencing: one read issued per cycle, one byte loaded per cycle, while the output register has room
   assign load  = pend_ff && out_free;
   assign issue = (remain_ff != '0) && (!pend_ff || out_free);
   assign fin   = load && (remain_ff == '0);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      flag_bits_in  = flag_bits_ff;
      flags_left_in = flags_left_ff;
      token_hi_in   = token_hi_ff;
      token_pend_in = token_pend_ff;
      remain_in     = remain_ff;
      pend_in       = pend_ff;
      last_in       = last_ff;
      cmd           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // consume one flag on a literal or a finished token
               if (is_copy || is_lit) begin
                  flag_bits_in = {1'b0, flag_bits_ff[7:1]};
                  if (flags_left_ff != '0) begin
                     flags_left_in = flags_left_ff - 1'b1;
                  end
               end
               if (is_copy) begin
                  token_pend_in = 1'b0;
                  cmd.rd_load   = 1'b1;
                  cmd.rd_pos    = {token_hi_ff, req_data.in_byte[7:4]};
                  remain_in     = LEN_W'(req_data.in_byte[3:0]) + LEN_W'(MIN_LEN);
                  pend_in       = 1'b0;
                  last_in       = req_data.in_last;
                  state_in      = ST_COPY;
               end
               if (is_flag) begin
                  flag_bits_in  = req_data.in_byte;
                  flags_left_in = FLAG_COUNT;
               end
               if (is_high) begin
                  token_hi_in   = req_data.in_byte;
                  token_pend_in = 1'b1;
               end
               // literal goes straight to the output
               if (is_lit) begin
                  cmd.load       = 1'b1;
                  cmd.out_byte   = req_data.in_byte;
                  cmd.byte_valid = 1'b1;
                  cmd.last_item  = 1'b1;
                  cmd.eos        = req_data.in_last;
               end
               // end-only marker when the final byte gave no data
               if (req_data.in_last && (is_flag || is_high)) begin
                  cmd.load      = 1'b1;
                  cmd.last_item = 1'b1;
                  cmd.eos       = 1'b1;
                  cmd.trunc     = is_high;
               end
               // end of stream returns parse state to its start
               if (req_data.in_last) begin
                  flag_bits_in  = '0;
                  flags_left_in = '0;
                  token_hi_in   = '0;
                  token_pend_in = 1'b0;
               end
            end
         end
         ST_COPY: begin
            cmd.load       = load;
            cmd.from_ram   = 1'b1;
            cmd.byte_valid = 1'b1;
            cmd.last_item  = fin;
            cmd.eos        = fin && last_ff;
            cmd.rd_issue   = issue;
            pend_in        = issue || (pend_ff && !load);
            remain_in      = remain_ff - LEN_W'(issue);
            if (fin) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         flag_bits_ff  <= '0;
         flags_left_ff <= '0;
         token_hi_ff   <= '0;
         token_pend_ff <= 1'b0;
         remain_ff     <= '0;
         pend_ff       <= 1'b0;
         last_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         token_hi_ff   <= token_hi_in;
         token_pend_ff <= token_pend_in;
         remain_ff     <= remain_in;
         pend_ff       <= pend_in;
         last_ff       <= last_in;
      end
   end

   // a token low byte starts a copy of at least the minimum length
   a_copy_start: assert property (@(posedge clock) disable iff (reset)
      (accept && is_copy) |=> (state_ff == ST_COPY && remain_ff >= LEN_W'(MIN_LEN)))
      else $error("copy did not start after token low byte");

   // the final copied byte returns the controller to idle
   a_copy_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && fin) |=> (state_ff == ST_IDLE))
      else $error("copy did not end after final byte");

   // no read data left pending outside a copy
   a_no_pend_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_ff)
      else $error("read pending while idle");

   // copy length stays in range
   a_remain_range: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= LEN_W'(MAX_LEN))
      else $error("copy count out of range");

endmodule

[sv/lzwd_dp.sv]
// datapath for the lzss window decompressor: window ram, write pointer, fill count,
// copy read pointer with write forwarding, output register; depends on lzwd_pkg, lzwd_ram
module lzwd_dp #(
   parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  lzwd_pkg::cmd_type cmd,
   output logic              out_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_data
);
   import lzwd_pkg::*;

   localparam int ADDR_W = $clog2(WINDOW_SIZE);
   localparam int FILL_W = ADDR_W + 1;
   localparam logic [ADDR_W-1:0] START = ADDR_W'(START_POS % WINDOW_SIZE);

   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [ADDR_W-1:0] rd_pos_ff, rd_pos_in;
   logic              hit_ff, hit_in;
   logic [7:0]        hit_byte_ff, hit_byte_in;
   logic              filled_ff, filled_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [7:0]        ram_q;
   logic [7:0]        rd_byte;
   logic [7:0]        out_byte;
   logic              win_we;
   logic [ADDR_W-1:0] rd_off;
   logic              filled_now;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // window byte: forwarded write, stored data, or zero for never-written entries
   assign rd_byte  = hit_ff ? hit_byte_ff : (filled_ff ? ram_q : 8'd0);
   assign out_byte = cmd.from_ram ? rd_byte : cmd.out_byte;
   assign win_we   = cmd.load && cmd.byte_valid;

   // entries written this stream form a run starting at the start position
   assign rd_off     = rd_pos_ff - START;
   assign filled_now = fill_ff[ADDR_W] || ({1'b0, rd_off} < fill_ff);

   lzwd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (win_we),
      .wr_addr (wp_ff),
      .wr_data (out_byte),
      .rd_en   (cmd.rd_issue),
      .rd_addr (rd_pos_ff),
      .rd_data (ram_q)
   );

   // pointer, fill count and output next values
   always_comb begin
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      rd_pos_in    = rd_pos_ff;
      hit_in       = hit_ff;
      hit_byte_in  = hit_byte_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // copy read pointer
      if (cmd.rd_load) begin
         rd_pos_in = ADDR_W'(cmd.rd_pos);
      end else if (cmd.rd_issue) begin
         rd_pos_in = rd_pos_ff + 1'b1;
      end
      // read metadata captured alongside the ram read
      if (cmd.rd_issue) begin
         hit_in      = win_we && (rd_pos_ff == wp_ff);
         hit_byte_in = out_byte;
         filled_in   = filled_now;
      end

      // window write pointer and fill count, restarted at end of stream
      if (cmd.load && cmd.eos) begin
         wp_in   = START;
         fill_in = '0;
      end else if (win_we) begin
         wp_in = wp_ff + 1'b1;
         if (!fill_ff[ADDR_W]) begin
            fill_in = fill_ff + 1'b1;
         end
      end

      // output register
      if (cmd.load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.out_byte       = cmd.byte_valid ? out_byte : 8'd0;
         rsp_data_in.byte_valid     = cmd.byte_valid;
         rsp_data_in.last_of_item   = cmd.last_item;
         rsp_data_in.end_of_stream  = cmd.eos;
         rsp_data_in.truncated      = cmd.trunc;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff        <= START;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_pos_ff   <= rd_pos_in;
      hit_ff      <= hit_in;
      hit_byte_ff <= hit_byte_in;
      filled_ff   <= filled_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the controller only loads when the output register has room
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      !(cmd.load && !out_free))
      else $error("output loaded while full");

   // fill count saturates at the window size
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_SIZE))
      else $error("fill count beyond window size");

   // end of stream restarts the window
   a_eos_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && cmd.eos) |=> (wp_ff == START && fill_ff == '0))
      else $error("window not restarted after end of stream");

   // a copy pointer load never coincides with a read
   a_load_no_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_load |-> !cmd.rd_issue)
      else $error("read issued while loading copy pointer");

endmodule

[sv/lzwd_top_placeholder.sv]
// top level wrapper is in lzss_window_decompressor.sv; this file holds no declarations
// depends on nothing; kept empty of logic

[sv/lzss_window_decompressor.sv]
// lzss decoder, 4096-byte window. flag, literal and token high bytes are taken while the
// output has room; a literal is in the output register in the cycle after its transfer.
// a copy token of length n (3..18) holds req_ready low until its last byte is loaded
// and sends one byte per cycle while the output has room, paced by the single window
// read port (registered read). reset (synchronous) and end of stream restart the window
// at position 4078; a fill count reads unwritten entries as zero, no clearing pass needed.
module lzss_window_decompressor #(
   parameter int WINDOW_SIZE = lzwd_pkg::WINDOW_SIZE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lzwd_pkg::rsp_type rsp_data
);
   import lzwd_pkg::*;

   cmd_type cmd;
   logic    out_free;

   // parser and copy sequencer
   lzwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   // window and output register
   lzwd_dp #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/lzwd_checker.sv]
// checker for the lzss window decompressor: watches both channels, decodes each
// accepted compressed byte into expected output bytes and compares every transfer
// depends on lzwd_pkg for the channel structs and token constants
module lzwd_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  lzwd_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  lzwd_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                pending,
   output int                bytes_out,
   output int                streams_done,
   output int                cut_streams
);
   timeunit 1ns;
   timeprecision 1ps;
   import lzwd_pkg::*;

   typedef enum logic [1:0] {
      AWAIT_FLAG_OR_ITEM = 2'd0,
      AWAIT_TOKEN_LOW    = 2'd1
   } decode_phase_type;

   // decoder state mirrored from the block
   logic [7:0]            window_mem [WINDOW_SIZE_DEF];
   logic [POS_W-1:0]      wr_pos;
   logic [7:0]            flag_reg;
   logic [FLAG_CNT_W-1:0] flags_left;
   logic [7:0]            tok_hi;
   decode_phase_type      phase;

   rsp_type expected_bytes[$];
   int      errors     = 0;
   int      byte_count = 0;
   int      stream_cnt = 0;
   int      cut_cnt    = 0;

   assign fail_count   = errors;
   assign bytes_out    = byte_count;
   assign streams_done = stream_cnt;
   assign cut_streams  = cut_cnt;

   // back to an empty window at the stream start point
   function automatic void restart_decoder();
      foreach (window_mem[i]) window_mem[i] = 8'h00;
      wr_pos     = POS_W'(START_POS);
      flag_reg   = 8'h00;
      flags_left = '0;
      tok_hi     = 8'h00;
      phase      = AWAIT_FLAG_OR_ITEM;
   endfunction

   // every emitted byte also lands in the window
   function automatic rsp_type store_byte(input logic [7:0] data_byte);
      rsp_type produced;
      window_mem[wr_pos] = data_byte;
      wr_pos = wr_pos + 1'b1;
      produced = '0;
      produced.out_byte = data_byte;
      produced.byte_valid = 1'b1;
      return produced;
   endfunction

   function automatic void take_flag();
      flag_reg = flag_reg >> 1;
      if (flags_left != 0) flags_left = flags_left - 1'b1;
   endfunction

   // expected output bytes for one compressed byte
   function automatic void decode_item(input req_type item);
      rsp_type          produced[$];
      rsp_type          tail;
      logic [15:0]      token;
      logic [POS_W-1:0] rd_pos;
      int               copy_len;
      logic             cut_short;
      cut_short = 1'b0;
      if (phase == AWAIT_TOKEN_LOW) begin
         // copy token: byte by byte, so overlapping sources repeat
         token    = {tok_hi, item.in_byte};
         rd_pos   = token[15:4];
         copy_len = int'(token[3:0]) + MIN_LEN;
         repeat (copy_len) begin
            produced.insert(produced.size(), store_byte(window_mem[rd_pos]));
            rd_pos = rd_pos + 1'b1;
         end
         take_flag();
         phase = AWAIT_FLAG_OR_ITEM;
      end else if (flags_left == 0) begin
         flag_reg   = item.in_byte;
         flags_left = FLAG_COUNT;
      end else if (flag_reg[0]) begin
         produced.insert(produced.size(), store_byte(item.in_byte));
         take_flag();
      end else begin
         tok_hi    = item.in_byte;
         phase     = AWAIT_TOKEN_LOW;
         cut_short = item.in_last;
      end
      // end of stream: marker if nothing was emitted, then a fresh window
      if (item.in_last) begin
         if (produced.size() == 0) begin
            tail = '0;
            produced.insert(0, tail);
         end
         tail = produced.pop_back();
         tail.end_of_stream = 1'b1;
         tail.truncated = cut_short;
         produced.insert(produced.size(), tail);
         stream_cnt++;
         if (cut_short) cut_cnt++;
         restart_decoder();
      end
      if (produced.size() != 0) begin
         tail = produced.pop_back();
         tail.last_of_item = 1'b1;
         produced.insert(produced.size(), tail);
      end
      foreach (produced[i]) expected_bytes.insert(expected_bytes.size(), produced[i]);
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         errors++;
      end
   endfunction

   // result transfers first: none can stem from a byte accepted at the same edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         restart_decoder();
         expected_bytes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("result with nothing expected: out_byte 0x%0h", rsp_data.out_byte);
               errors++;
            end else begin
               want = expected_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_data.out_byte);
               check_field("byte_valid", want.byte_valid, rsp_data.byte_valid);
               check_field("last_of_item", want.last_of_item, rsp_data.last_of_item);
               check_field("end_of_stream", want.end_of_stream, rsp_data.end_of_stream);
               check_field("truncated", want.truncated, rsp_data.truncated);
               if (want.byte_valid) byte_count++;
            end
         end
         if (req_valid && req_ready) decode_item(req_data);
      end
      pending <= expected_bytes.size();
   end

endmodule

[tb/lzss_window_decompressor_tb.sv]
// testbench top for the lzss window decompressor: clock, reset, stream stimulus and verdict
// depends on lzwd_pkg, lzss_window_decompressor and lzwd_checker
module lzss_window_decompressor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lzwd_pkg::*;

   localparam int TARGET_ITEMS = 260;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 24;

   typedef enum logic [1:0] {
      END_ON_ITEM,
      END_MID_TOKEN,
      END_ON_FLAG
   } stream_end_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic quiet       = 1'b0;
   int   items_sent  = 0;
   int   idle_cycles = 0;
   int   fail_count, pending, bytes_out, streams_done, cut_streams;

   lzss_window_decompressor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lzwd_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .fail_count   (fail_count),
      .pending      (pending),
      .bytes_out    (bytes_out),
      .streams_done (streams_done),
      .cut_streams  (cut_streams)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver stalls at random outside the quiet stretch
   always @(posedge clock) begin
      rsp_ready <= quiet || ($urandom_range(0, 99) >= 16);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("no transfer for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one compressed byte, with random gaps before it
   task automatic send_byte(input logic [7:0] data_byte, input logic is_last);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 16) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= '{in_byte: data_byte, in_last: is_last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // hand-built streams: trailing flag, literal extremes, overlapping and wrapping
   // copies, a read of the cleared window, a cut-short token, a copy that ends a stream
   task automatic directed_streams();
      send_byte(8'h00, 1'b1);
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h2F, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h10, 1'b0);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h5F, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      send_byte(8'hAB, 1'b1);
      send_byte(8'hFE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // well-formed stream with random content, at times cut inside a token; copies mostly reach back a short way
   task automatic random_stream();
      req_type          stream_q[$];
      req_type          cur;
      logic [7:0]       flags;
      logic [POS_W-1:0] gen_pos;
      logic [POS_W-1:0] src;
      logic [3:0]       code;
      stream_end_type   ending;
      int               groups;
      int               nflags;
      int               pick;
      gen_pos = POS_W'(START_POS);
      groups  = $urandom_range(1, 3);
      pick    = $urandom_range(0, 9);
      ending  = (pick < 2) ? END_MID_TOKEN : (pick == 2) ? END_ON_FLAG : END_ON_ITEM;
      nflags  = 8;
      for (int g = 0; g < groups; g++) begin
         flags  = 8'($urandom);
         nflags = (g == groups - 1 && ending != END_ON_FLAG) ? $urandom_range(1, 8) : 8;
         if (g == groups - 1 && ending == END_MID_TOKEN && nflags < 8) flags[nflags] = 1'b0;
         cur = '{in_byte: flags, in_last: 1'b0};
         stream_q.insert(stream_q.size(), cur);
         for (int f = 0; f < nflags; f++) begin
            if (flags[f]) begin
               cur = '{in_byte: 8'($urandom), in_last: 1'b0};
               stream_q.insert(stream_q.size(), cur);
               gen_pos = gen_pos + 1'b1;
            end else begin
               code = 4'($urandom);
               if ($urandom_range(0, 9) < 7) src = gen_pos - POS_W'($urandom_range(1, 48));
               else src = POS_W'($urandom);
               cur = '{in_byte: src[11:4], in_last: 1'b0};
               stream_q.insert(stream_q.size(), cur);
               cur = '{in_byte: {src[3:0], code}, in_last: 1'b0};
               stream_q.insert(stream_q.size(), cur);
               gen_pos = gen_pos + code + POS_W'(MIN_LEN);
            end
         end
      end
      if (ending == END_MID_TOKEN) begin
         if (nflags == 8) begin
            cur = '{in_byte: 8'($urandom) & 8'hFE, in_last: 1'b0};
            stream_q.insert(stream_q.size(), cur);
         end
         cur = '{in_byte: 8'($urandom), in_last: 1'b0};
         stream_q.insert(stream_q.size(), cur);
      end else if (ending == END_ON_FLAG) begin
         cur = '{in_byte: 8'($urandom), in_last: 1'b0};
         stream_q.insert(stream_q.size(), cur);
      end
      cur = stream_q.pop_back();
      cur.in_last = 1'b1;
      stream_q.insert(stream_q.size(), cur);
      foreach (stream_q[i]) send_byte(stream_q[i].in_byte, stream_q[i].in_last);
   endtask

   // raw bytes with scattered stream ends
   task automatic noise_stream();
      int len;
      len = $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom), (i == len - 1) || ($urandom_range(0, 19) == 0));
      end
   endtask

   initial begin
      int random_goal;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed_streams();
      random_goal = TARGET_ITEMS;
      while (items_sent < random_goal) begin
         // a stretch in the middle runs with neither side idling
         quiet <= (items_sent > random_goal - 170) && (items_sent < random_goal - 100);
         if ($urandom_range(0, 99) < 15) noise_stream();
         else random_stream();
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d compressed bytes in %0d streams, %0d of them cut inside a token",
               items_sent, streams_done, cut_streams);
      $display("rebuilt %0d output bytes through the window", bytes_out);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
sv/lzwd_pkg.sv
sv/lzwd_ram.sv
sv/lzwd_ctrl.sv
sv/lzwd_dp.sv
sv/lzwd_top_placeholder.sv
sv/lzss_window_decompressor.sv
tb/lzwd_checker.sv
tb/lzss_window_decompressor_tb.sv
